### sv/fgo_pkg.sv
// Shared types and constants for the FONTX glyph offset block.
package fgo_pkg;

    // Default depth of the code range table
    localparam int MAX_BLOCKS_DEF = 64;

    // Fixed field widths
    localparam int CODE_W   = 16;
    localparam int IDX_W    = 6;
    localparam int OFF_W    = 30;
    localparam int CFG_W    = 8;
    localparam int BCNT_W   = 7;
    localparam int BLK_W    = 8;   // holds any clamped block count
    localparam int SIZE_W   = 13;  // 32 bytes per row * 255 rows
    localparam int BASE_W   = 11;  // 18 + 4*255
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 32;

    // Header offsets
    localparam logic [BASE_W-1:0] SB_BASE = BASE_W'(17);
    localparam logic [BASE_W-1:0] DB_BASE = BASE_W'(18);
    localparam logic [OFF_W-1:0]  OFF_LIMIT = '1;

    // Request kinds
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_CHAR_WIDTH  = 2'd0,
        REG_CHAR_HEIGHT = 2'd1,
        REG_DOUBLE_BYTE = 2'd2,
        REG_BLOCK_COUNT = 2'd3
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_ADD
    } t_state;

endpackage

### sv/fgo_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fgo_ram
    import fgo_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = MAX_BLOCKS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/fontx_glyph_offset_core.sv
// Top level of the FONTX glyph offset lookup: sequencer, range walk and offset math.
//
// A write request (tuser = 1) stores one code range in the table when its
// index is below MAX_BLOCKS. A lookup request (tuser = 0) on a single-byte
// font passes through request capture, offset multiply and base add into the
// result register. On a double-byte font the sequencer walks the range table
// through its single read port, one entry per cycle, up to min(block_count,
// MAX_BLOCKS) entries, and stops early when a range holds the code. The input
// side is not ready while a lookup is in progress; a finished result sits in
// the output register while the next request is taken. The table holds
// garbage after reset until each entry used by a lookup has been written.
module fontx_glyph_offset_core
    import fgo_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // code[15:0], block_index[21:16], range_start[37:22], range_end[53:38], zero pad
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // cmd
    input  logic                i_s_tuser,
    // result stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // byte_offset[29:0], zero pad
    output logic [M_DATA_W-1:0] o_m_tdata,
    // found
    output logic                o_m_tuser,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW     = $clog2(MAX_BLOCKS + 1);
    localparam int ACC_W  = CODE_W + CW;
    localparam int PROD_W = ACC_W + SIZE_W;
    localparam int SUM_W  = PROD_W + 1;

    // request fields
    logic [CODE_W-1:0] s_code;
    logic [IDX_W-1:0]  s_idx;
    logic [CODE_W-1:0] s_first;
    logic [CODE_W-1:0] s_last;
    assign s_code  = i_s_tdata[15:0];
    assign s_idx   = i_s_tdata[21:16];
    assign s_first = i_s_tdata[37:22];
    assign s_last  = i_s_tdata[53:38];

    // configuration registers
    logic [CFG_W-1:0]  r_char_width;
    logic [CFG_W-1:0]  r_char_height;
    logic              r_double_byte;
    logic [BCNT_W-1:0] r_block_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_width  <= CFG_W'(8);
            r_char_height <= CFG_W'(16);
            r_double_byte <= 1'b0;
            r_block_count <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_CHAR_WIDTH:  r_char_width  <= i_cfg_data;
                REG_CHAR_HEIGHT: r_char_height <= i_cfg_data;
                REG_DOUBLE_BYTE: r_double_byte <= i_cfg_data[0];
                REG_BLOCK_COUNT: r_block_count <= i_cfg_data[BCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // glyph size = ceil(width/8) * height
    logic [8:0]        w_round;
    logic [5:0]        row_bytes;
    logic [SIZE_W-1:0] glyph_size;
    assign w_round    = {1'b0, r_char_width} + 9'd7;
    assign row_bytes  = w_round[8:3];
    assign glyph_size = SIZE_W'(row_bytes) * SIZE_W'(r_char_height);

    // block count clamped to the table depth
    logic [BLK_W-1:0] bc_ext;
    logic [BLK_W-1:0] bc_clamp;
    assign bc_ext   = {1'b0, r_block_count};
    assign bc_clamp = (bc_ext > BLK_W'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS) : bc_ext;

    // sequencer and datapath registers
    t_state              r_state, n_state;
    logic [CW-1:0]       r_blocks, n_blocks;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [BASE_W-1:0]   r_base, n_base;
    logic                r_ok, n_ok;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic                r_out_valid, n_out_valid;
    logic                r_out_found, n_out_found;
    logic [OFF_W-1:0]    r_out_off, n_out_off;

    // range table: {last, first}
    logic                  s_accept;
    logic                  tbl_we;
    logic [BLK_W-1:0]      widx_ext;
    logic                  rd_en;
    logic [2*CODE_W-1:0]   rd_data;
    logic [CODE_W-1:0]     ent_first;
    logic [CODE_W-1:0]     ent_last;

    assign s_accept  = i_s_tvalid && o_s_tready;
    assign widx_ext  = BLK_W'(s_idx);
    assign tbl_we    = s_accept && (i_s_tuser == CMD_WRITE)
                       && (widx_ext < BLK_W'(MAX_BLOCKS));
    assign ent_first = rd_data[CODE_W-1:0];
    assign ent_last  = rd_data[2*CODE_W-1:CODE_W];

    fgo_ram #(
        .WIDTH (2 * CODE_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ranges (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (widx_ext[AW-1:0]),
        .i_wdata ({s_last, s_first}),
        .i_re    (rd_en),
        .i_raddr (AW'(r_idx)),
        .o_rdata (rd_data)
    );

    // per-entry compare and count, final add
    logic               ent_hit;
    logic               ent_valid;
    logic [CODE_W:0]    ent_span;
    logic [SUM_W-1:0]   sum;
    logic               out_free;

    assign ent_valid = ent_last >= ent_first;
    assign ent_hit   = ent_valid && (r_code >= ent_first) && (r_code <= ent_last);
    assign ent_span  = {1'b0, ent_last} - {1'b0, ent_first} + (CODE_W+1)'(1);
    assign sum       = {1'b0, r_prod} + SUM_W'(r_base);
    assign out_free  = !r_out_valid || i_m_tready;

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_blocks    = r_blocks;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_acc       = r_acc;
        n_code      = r_code;
        n_size      = r_size;
        n_base      = r_base;
        n_ok        = r_ok;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_found = r_out_found;
        n_out_off   = r_out_off;
        rd_en       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept && i_s_tuser == CMD_LOOKUP) begin
                    n_code   = s_code;
                    n_size   = glyph_size;
                    n_acc    = ACC_W'(s_code);
                    n_blocks = CW'(bc_clamp);
                    n_idx    = '0;
                    if (r_double_byte) begin
                        n_acc   = '0;
                        n_ok    = 1'b1;
                        n_base  = DB_BASE + {bc_clamp, 2'b00};
                        n_state = ST_WALK;
                    end else begin
                        n_ok    = (s_code[15:8] == 8'd0);
                        n_base  = SB_BASE;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_WALK: begin
                if (r_pend && ent_hit) begin
                    // code found: add its place inside the range
                    n_acc   = r_acc + ACC_W'(r_code - ent_first);
                    n_state = ST_MUL;
                end else begin
                    if (r_pend && ent_valid) begin
                        n_acc = r_acc + ACC_W'(ent_span);
                    end
                    if (r_idx < r_blocks) begin
                        rd_en  = 1'b1;
                        n_idx  = r_idx + CW'(1);
                        n_pend = 1'b1;
                    end else if (!r_pend) begin
                        // table exhausted
                        n_ok    = 1'b0;
                        n_state = ST_ADD;
                    end
                end
            end
            ST_MUL: begin
                n_prod  = PROD_W'(r_acc) * PROD_W'(r_size);
                n_state = ST_ADD;
            end
            ST_ADD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_ok && (sum <= SUM_W'(OFF_LIMIT));
                    n_out_off   = n_out_found ? sum[OFF_W-1:0] : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_blocks    <= n_blocks;
        r_idx       <= n_idx;
        r_acc       <= n_acc;
        r_code      <= n_code;
        r_size      <= n_size;
        r_base      <= n_base;
        r_ok        <= n_ok;
        r_prod      <= n_prod;
        r_out_found <= n_out_found;
        r_out_off   <= n_out_off;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_found;
    assign o_m_tdata  = {{(M_DATA_W-OFF_W){1'b0}}, r_out_off};

    // a lookup request always leaves idle
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tuser == CMD_LOOKUP) |=> (r_state != ST_IDLE))
        else $error("lookup accepted but sequencer stayed idle");

    // walk never reads past the clamped block count
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_idx <= r_blocks))
        else $error("range walk index beyond block count");

    // a miss carries a zero offset
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("not-found result with nonzero offset");

    // read data is only consumed in the walk, in the cycle after a read
    a_pend_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(rd_en) && r_state == ST_WALK))
        else $error("range entry used without a read");

endmodule
